// ----- hw/rtl/gkg_pkg.sv -----
package gkg_pkg;

	localparam int NUM_W = 43;
	localparam int DEN_W = 28;
	localparam logic [16:0] LOG2E_Q16 = 17'd94548;
	localparam logic [17:0] RAW_ONE = 18'd131072;

	typedef logic [29:0] pow_tab_t [16];

	typedef enum logic [3:0] {
		S_IDLE,
		S_XSTART,
		S_XDIV,
		S_YMUL,
		S_EXP,
		S_STORE,
		S_RSTART,
		S_WSTART,
		S_WDIV,
		S_OUT
	} state_t;

	typedef struct packed {
		logic load;
		logic div_x_start;
		logic div_w_start;
		logic div_step;
		logic mul_y;
		logic exp_step;
		logic store;
		logic idx_inc;
		logic idx_clr;
		logic ram_read;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic exp_done;
		logic idx_last;
	} status_t;

	function automatic logic [63:0] isqrt64(logic [63:0] v);
		logic [63:0] res;
		logic [63:0] bit_v;
		logic [63:0] rem;
		res = '0;
		bit_v = 64'd1 << 62;
		rem = v;
		for (int k = 0; k < 32; k++) begin
			if (rem >= res + bit_v) begin
				rem = rem - (res + bit_v);
				res = (res >> 1) + bit_v;
			end else begin
				res = res >> 1;
			end
			bit_v = bit_v >> 2;
		end
		return res;
	endfunction

	// entry k holds 2^(-2^-(k+1)) in Q30
	function automatic pow_tab_t build_pow_tab();
		pow_tab_t tab;
		logic [63:0] t;
		t = isqrt64(64'd1 << 59);
		tab[0] = t[29:0];
		for (int j = 1; j < 16; j++) begin
			t = isqrt64(t << 30);
			tab[j] = t[29:0];
		end
		return tab;
	endfunction

endpackage

// ----- hw/rtl/gaussian_kernel_generator_unit.sv -----
// Gaussian kernel generator.
// Input channel (in_valid/in_ready, sigma_q8): one transfer per kernel, sigma in Q6.8.
// Output channel (out_valid/out_ready): radius+1 transfers, centre tap first, each
// carrying tap_index, tap_weight (Q0.16, saturated), kernel_radius and last_tap.
// A new sigma is taken only when the previous kernel has been fully drained.
// Build phase, per tap: 43-step restoring divide, y multiply, 16-step exp
// product chain, store. Emit phase, per tap: raw weight RAM read, 43-step
// normalizing divide, output. Both phases share one serial divider.
// The output stays registered and held while out_ready is low; the block waits.
// Reset (arst_n low) returns the controller to idle with no output pending.
// Raw weights live in a small RAM; every entry is written before it is read.
module gaussian_kernel_generator_unit #(
	parameter int MAX_RADIUS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [13:0] sigma_q8,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [5:0]  tap_index,
	output logic [15:0] tap_weight,
	output logic [5:0]  kernel_radius,
	output logic        last_tap
);
	import gkg_pkg::*;

	cmd_t    cmd;
	status_t sts;

	gkg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	gkg_datapath #(.MAX_RADIUS(MAX_RADIUS)) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.sigma_q8      (sigma_q8),
		.cmd           (cmd),
		.sts           (sts),
		.tap_index     (tap_index),
		.tap_weight    (tap_weight),
		.kernel_radius (kernel_radius),
		.last_tap      (last_tap)
	);

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input taken while kernel pending");

	a_last_at_radius: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && last_tap) |-> (tap_index == kernel_radius))
		else $error("last tap not at radius");

	a_radius_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (32'(kernel_radius) <= MAX_RADIUS)) else $error("radius over max");

	a_idle_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && last_tap) |=> in_ready)
		else $error("not idle after last tap");

endmodule

// ----- hw/rtl/gkg_ram.sv -----
module gkg_ram #(
	parameter int WIDTH = 18,
	parameter int DEPTH = 33
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- hw/rtl/gkg_ctrl.sv -----
module gkg_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	input  gkg_pkg::status_t sts,
	output gkg_pkg::cmd_t   cmd
);
	import gkg_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:   if (in_valid) state_d = S_XSTART;
			S_XSTART: state_d = S_XDIV;
			S_XDIV:   if (sts.div_done) state_d = S_YMUL;
			S_YMUL:   state_d = S_EXP;
			S_EXP:    if (sts.exp_done) state_d = S_STORE;
			S_STORE:  state_d = sts.idx_last ? S_RSTART : S_XSTART;
			S_RSTART: state_d = S_WSTART;
			S_WSTART: state_d = S_WDIV;
			S_WDIV:   if (sts.div_done) state_d = S_OUT;
			S_OUT:    if (out_ready) state_d = sts.idx_last ? S_IDLE : S_RSTART;
			default:  state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			S_XSTART: cmd.div_x_start = 1'b1;
			S_XDIV: begin
				cmd.div_step = !sts.div_done;
			end
			S_YMUL: cmd.mul_y = 1'b1;
			S_EXP: cmd.exp_step = !sts.exp_done;
			S_STORE: begin
				cmd.store = 1'b1;
				cmd.idx_clr = sts.idx_last;
				cmd.idx_inc = !sts.idx_last;
			end
			S_RSTART: cmd.ram_read = 1'b1;
			S_WSTART: cmd.div_w_start = 1'b1;
			S_WDIV: begin
				cmd.div_step = !sts.div_done;
				cmd.out_load = sts.div_done;
			end
			S_OUT: begin
				out_valid = 1'b1;
				cmd.idx_inc = out_ready && !sts.idx_last;
			end
			default: ;
		endcase
	end

endmodule

// ----- hw/rtl/gkg_datapath.sv -----
module gkg_datapath #(
	parameter int MAX_RADIUS = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [13:0]      sigma_q8,
	input  gkg_pkg::cmd_t    cmd,
	output gkg_pkg::status_t sts,
	output logic [5:0]       tap_index,
	output logic [15:0]      tap_weight,
	output logic [5:0]       kernel_radius,
	output logic             last_tap
);
	import gkg_pkg::*;

	localparam int AW = $clog2(MAX_RADIUS + 1);
	localparam logic [7:0] MAX_RAD8 = 8'(MAX_RADIUS);
	localparam pow_tab_t POW_TAB = build_pow_tab();

	logic [5:0]       rad_q;
	logic [5:0]       idx_q;
	logic [DEN_W-1:0] den_q;
	logic [23:0]      total_q;
	logic [NUM_W-1:0] num_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W:0]   rem_q;
	logic [DEN_W-1:0] dvs_q;
	logic [5:0]       dcnt_q;
	logic [4:0]       n_q;
	logic [15:0]      f_q;
	logic [4:0]       j_q;
	logic [30:0]      r_q;
	logic             tail_q;
	logic [5:0]       tap_index_q;
	logic [15:0]      tap_weight_q;
	logic             last_q;

	logic [7:0]       rad_full;
	logic [5:0]       rad_new;
	logic [DEN_W:0]   rem_sh;
	logic             ge;
	logic [36:0]      prod_y;
	logic [60:0]      prod_e;
	logic [5:0]       sh;
	logic [39:0]      rnd;
	logic [17:0]      raw;
	logic [17:0]      ram_rdata;
	logic [11:0]      idx_sq;
	logic [34:0]      num_w;

	assign rad_full = 8'((15'(sigma_q8) + 15'd127) >> 7);
	assign rad_new  = (rad_full > MAX_RAD8) ? MAX_RAD8[5:0] : rad_full[5:0];
	assign idx_sq   = 12'(idx_q * idx_q);
	assign num_w    = {1'b0, ram_rdata, 16'b0} + 35'(total_q >> 1);

	assign rem_sh = {rem_q[DEN_W-1:0], num_q[NUM_W-1]};
	assign ge     = rem_sh >= {1'b0, dvs_q};

	assign prod_y = 37'(quo_q[19:0] * LOG2E_Q16) + 37'd32768;
	assign prod_e = r_q * POW_TAB[j_q[3:0]];

	assign sh  = 6'(n_q) + 6'd13;
	assign rnd = ({9'b0, r_q} + (40'd1 << (sh - 6'd1))) >> sh;
	assign raw = (idx_q == 6'd0) ? RAW_ONE : (tail_q ? 18'd0 : rnd[17:0]);

	assign sts.div_done = dcnt_q == 6'd0;
	assign sts.exp_done = j_q == 5'd16;
	assign sts.idx_last = idx_q == rad_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rad_q <= '0;
			total_q <= '0;
			idx_q <= '0;
			dcnt_q <= '0;
			j_q <= '0;
		end else begin
			if (cmd.load) begin
				rad_q <= rad_new;
				total_q <= '0;
				idx_q <= '0;
			end
			if (cmd.idx_inc) idx_q <= idx_q + 6'd1;
			if (cmd.idx_clr) idx_q <= '0;
			if (cmd.store) begin
				total_q <= total_q + ((idx_q == 6'd0) ? 24'(raw) : 24'({raw, 1'b0}));
			end
			if (cmd.div_x_start || cmd.div_w_start) dcnt_q <= 6'(NUM_W);
			if (cmd.div_step) dcnt_q <= dcnt_q - 6'd1;
			if (cmd.mul_y) j_q <= '0;
			if (cmd.exp_step) j_q <= j_q + 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			den_q <= DEN_W'(sigma_q8 * sigma_q8);
		end
		if (cmd.div_x_start) begin
			num_q <= {idx_sq, 31'b0};
			dvs_q <= den_q;
			rem_q <= '0;
		end
		if (cmd.div_w_start) begin
			num_q <= NUM_W'(num_w);
			dvs_q <= DEN_W'(total_q);
			rem_q <= '0;
		end
		if (cmd.div_step) begin
			num_q <= {num_q[NUM_W-2:0], 1'b0};
			quo_q <= {quo_q[NUM_W-2:0], ge};
			rem_q <= ge ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
		end
		if (cmd.mul_y) begin
			n_q <= prod_y[36:32];
			f_q <= prod_y[31:16];
			tail_q <= |quo_q[NUM_W-1:20];
			r_q <= 31'd1 << 30;
		end
		if (cmd.exp_step) begin
			f_q <= {f_q[14:0], 1'b0};
			if (f_q[15]) r_q <= 31'((prod_e + 61'd536870912) >> 30);
		end
		if (cmd.out_load) begin
			tap_index_q <= idx_q;
			last_q <= idx_q == rad_q;
			if (total_q == 24'd0) begin
				tap_weight_q <= '0;
			end else if (|quo_q[NUM_W-1:16]) begin
				tap_weight_q <= 16'hFFFF;
			end else begin
				tap_weight_q <= quo_q[15:0];
			end
		end
	end

	gkg_ram #(.WIDTH(18), .DEPTH(MAX_RADIUS + 1)) u_ram (
		.clk   (clk),
		.we    (cmd.store),
		.waddr (idx_q[AW-1:0]),
		.wdata (raw),
		.re    (cmd.ram_read),
		.raddr (idx_q[AW-1:0]),
		.rdata (ram_rdata)
	);

	assign tap_index     = tap_index_q;
	assign tap_weight    = tap_weight_q;
	assign kernel_radius = rad_q;
	assign last_tap      = last_q;

endmodule
